/* hw/rtl/bpkt_pkg.sv */
// Package for the bounded priority key table.
// Holds sizes, operation and status codes, and the entry and RAM write types.
// No dependencies.
`default_nettype none
package bpkt_pkg;

  localparam int CAPACITY      = 16;
  localparam int KEY_BITS      = 64;
  localparam int PRIORITY_BITS = 32;
  localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int CFG_W         = 5;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_REDUNDANT = 3'd1;
  localparam logic [2:0] ST_REJECTED  = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_PRESENT   = 3'd5;
  localparam logic [2:0] ST_ABSENT    = 3'd6;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]      key;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } ram_wr_t;

endpackage
`default_nettype wire

/* hw/rtl/bpkt_req_if.sv */
// Request channel of the bounded priority key table.
// Depends on bpkt_pkg.
`default_nettype none
interface bpkt_req_if;
  import bpkt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [KEY_BITS-1:0]      key;
  logic [PRIORITY_BITS-1:0] priority_req;

  modport source (output valid, kind, key, priority_req, input ready);
  modport sink (input valid, kind, key, priority_req, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bpkt_rsp_if.sv */
// Response channel of the bounded priority key table.
// Depends on bpkt_pkg.
`default_nettype none
interface bpkt_rsp_if;
  import bpkt_pkg::*;

  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, status, entry_count, input ready);
  modport sink (input valid, status, entry_count, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bpkt_cfg_if.sv */
// Configuration write channel carrying the entry limit.
// Depends on bpkt_pkg.
`default_nettype none
interface bpkt_cfg_if;
  import bpkt_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] max_entries;

  modport source (output valid, max_entries, input ready);
  modport sink (input valid, max_entries, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bpkt_ram.sv */
// Entry storage: one write port and one read port with registered read data.
// Depends on bpkt_pkg.
`default_nettype none
module bpkt_ram (
  input  wire logic             clk,
  input  wire bpkt_pkg::ram_wr_t wr,
  input  wire bpkt_pkg::idx_t    rd_addr,
  output bpkt_pkg::entry_t       rd_data
);
  import bpkt_pkg::*;

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

/* hw/rtl/bounded_priority_key_table.sv */
// Bounded priority key table: a sequencer around one entry RAM.
// Depends on bpkt_pkg, the three channel interfaces and bpkt_ram.
//
// The req channel carries add, remove and query operations. Each accepted
// request gives exactly one transfer on rsp with a status and the entry count.
// The cfg channel writes the entry limit; it is always ready, and a write is
// ignored while the table holds any key. Values above the capacity are clamped.
// One request is worked at a time. The entry RAM is scanned one entry per
// cycle, then comes a decision step, then the shift that opens or closes a
// gap moves one entry per cycle, then the response register is loaded. The
// next request is taken the cycle after that load. The registered RAM read
// port paces the scan and the shift. Reset empties the table and sets the
// limit to the capacity; no RAM clearing is needed since only entries below
// the count are read. A stalled response holds its register; the block then
// finishes the next request up to the response load and waits there.
`default_nettype none
module bounded_priority_key_table (
  input wire logic clk,
  input wire logic rst,
  bpkt_req_if.sink   req,
  bpkt_rsp_if.source rsp,
  bpkt_cfg_if.sink   cfg
);
  import bpkt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_FIN} state_t;

  state_t                   state;
  logic [1:0]               kind_r;
  logic [KEY_BITS-1:0]      key_r;
  logic [PRIORITY_BITS-1:0] prio_r;
  cnt_t                     count;
  cnt_t                     limit;
  cnt_t                     ptr;
  cnt_t                     rem;
  logic                     pend;
  idx_t                     pend_idx;
  logic                     found;
  idx_t                     at;
  logic                     pos_found;
  idx_t                     pos;
  logic [PRIORITY_BITS-1:0] last_prio;
  logic                     up;
  logic                     ins;
  idx_t                     ins_pos;
  logic [2:0]               status_r;
  logic                     rsp_valid;
  logic [2:0]               rsp_status;
  cnt_t                     rsp_count;

  ram_wr_t wr;
  entry_t  rd_data;
  cnt_t    keep_count;

  bpkt_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (ptr[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign req.ready       = (state == S_IDLE);
  assign cfg.ready       = 1'b1;
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.entry_count = rsp_count;

  assign keep_count = (count >= limit) ? count - cnt_t'(1) : count;

  always_comb begin
    wr = '0;
    if (state == S_SHIFT) begin
      if (pend) begin
        wr.en   = 1'b1;
        wr.addr = up ? pend_idx + idx_t'(1) : pend_idx - idx_t'(1);
        wr.data = rd_data;
      end else if (rem == '0 && ins) begin
        wr.en        = 1'b1;
        wr.addr      = ins_pos;
        wr.data.key  = key_r;
        wr.data.prio = prio_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      limit     <= cnt_t'(CAPACITY);
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid && count == '0) begin
        if (int'(cfg.max_entries) > CAPACITY) begin
          limit <= cnt_t'(CAPACITY);
        end else begin
          limit <= cnt_t'(cfg.max_entries);
        end
      end
      if (rsp.ready && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind_r    <= req.kind;
            key_r     <= req.key;
            prio_r    <= req.priority_req;
            ptr       <= '0;
            pend      <= 1'b0;
            found     <= 1'b0;
            pos_found <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (pend) begin
            if (rd_data.key == key_r && !found) begin
              found <= 1'b1;
              at    <= pend_idx;
            end
            if (prio_r > rd_data.prio && !pos_found) begin
              pos_found <= 1'b1;
              pos       <= pend_idx;
            end
            last_prio <= rd_data.prio;
          end
          if (ptr < count) begin
            ptr      <= ptr + cnt_t'(1);
            pend     <= 1'b1;
            pend_idx <= ptr[IDX_W-1:0];
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          pend <= 1'b0;
          case (kind_r)
            KIND_ADD: begin
              if (found) begin
                status_r <= ST_REDUNDANT;
                state    <= S_FIN;
              end else if (limit == '0) begin
                status_r <= ST_REJECTED;
                state    <= S_FIN;
              end else if (count >= limit && last_prio >= prio_r) begin
                status_r <= ST_REJECTED;
                state    <= S_FIN;
              end else begin
                status_r <= ST_ADDED;
                ins      <= 1'b1;
                up       <= 1'b1;
                ins_pos  <= pos_found ? pos : keep_count[IDX_W-1:0];
                rem      <= keep_count - (pos_found ? cnt_t'(pos) : keep_count);
                ptr      <= keep_count - cnt_t'(1);
                count    <= keep_count + cnt_t'(1);
                state    <= S_SHIFT;
              end
            end
            KIND_REMOVE: begin
              if (!found) begin
                status_r <= ST_NOT_FOUND;
                state    <= S_FIN;
              end else begin
                status_r <= ST_REMOVED;
                ins      <= 1'b0;
                up       <= 1'b0;
                rem      <= count - cnt_t'(1) - cnt_t'(at);
                ptr      <= cnt_t'(at) + cnt_t'(1);
                count    <= count - cnt_t'(1);
                state    <= S_SHIFT;
              end
            end
            default: begin
              status_r <= found ? ST_PRESENT : ST_ABSENT;
              state    <= S_FIN;
            end
          endcase
        end
        S_SHIFT: begin
          if (rem != '0) begin
            ptr      <= up ? ptr - cnt_t'(1) : ptr + cnt_t'(1);
            rem      <= rem - cnt_t'(1);
            pend     <= 1'b1;
            pend_idx <= ptr[IDX_W-1:0];
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= status_r;
            rsp_count  <= count;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/bpkt_checker.sv */
// Port-level checks for the bounded priority key table, bound to the top level.
// Depends on bpkt_pkg and bounded_priority_key_table.
`default_nettype none
module bpkt_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             req_valid,
  input wire logic             req_ready,
  input wire logic             rsp_valid,
  input wire logic             rsp_ready,
  input wire logic [2:0]       status,
  input wire bpkt_pkg::cnt_t   entry_count
);
  import bpkt_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entry_count))
    else $error("Stalled response changed.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("Request taken while another is in work.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> int'(entry_count) <= CAPACITY)
    else $error("Entry count above capacity.");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_ADDED || status == ST_PRESENT || status == ST_REDUNDANT)
      |-> entry_count != '0)
    else $error("Key reported held in an empty table.");
endmodule

bind bounded_priority_key_table bpkt_checker u_bpkt_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .entry_count (rsp.entry_count)
);
`default_nettype wire
